### rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam logic [31:0] HASH_MULT = 32'd2654435761;
	localparam int CNT_W = 9;
	localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 9'd192;
	localparam logic REG_MAX_ENTRIES = 1'b0;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_DONE = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SLOT_EMPTY   = 2'd0,
		SLOT_USED    = 2'd1,
		SLOT_DELETED = 2'd2
	} slot_state_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic               found;
		logic signed [31:0] value_out;
		status_t            status;
		logic [CNT_W-1:0]   entry_count_out;
	} rsp_t;

	// write controls into the slot store
	typedef struct packed {
		logic        slot_we;
		slot_state_t slot;
		logic        key_we;
		logic        value_we;
	} store_wr_t;

endpackage

### rtl/lpht_if.sv
// ----------------------------------------------------------------------------
// lpht_if
// Valid/ready channels for requests and responses of the hash table.
// ----------------------------------------------------------------------------
interface lpht_req_if import lpht_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface lpht_rsp_if import lpht_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

### rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing key/value table with multiplicative hash and linear probing.
// ----------------------------------------------------------------------------
// Each request is accepted while idle, then is hashed, visits the slots on
// its probe path in turn (1 up to TABLE_SLOTS slots), and commits the
// update and loads the response; the commit waits while the previous
// response is still held and not taken. The probe rate is set by the single
// read port of the slot store, which returns one slot per cycle. A clear
// sweeps the slot state memory one slot per cycle and then commits its
// response; the same sweep runs after reset, with no response, before the
// first request is taken.
// The response sits in an output register, so the next request may be
// accepted while the previous response is still waiting to transfer.
// ----------------------------------------------------------------------------
module linear_probe_hash_table import lpht_pkg::*; #(
	parameter int TABLE_SLOTS = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	lpht_req_if.sink     req,
	lpht_rsp_if.source   rsp,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int IDX_W = $clog2(TABLE_SLOTS);
	localparam int SLOT_W = IDX_W + 1;
	localparam logic [IDX_W-1:0] MULT_LO = IDX_W'(HASH_MULT);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
	localparam logic [SLOT_W-1:0] LAST_PROBE = SLOT_W'(TABLE_SLOTS - 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_HASH   = 5'b00010,
		ST_PROBE  = 5'b00100,
		ST_COMMIT = 5'b01000,
		ST_CLEAR  = 5'b10000
	} state_t;

	state_t             state_q;
	op_t                op_q;
	logic [31:0]        key_q;
	logic [31:0]        value_q;
	logic [IDX_W-1:0]   idx_q;
	logic [SLOT_W-1:0]  n_q;
	logic [IDX_W-1:0]   free_q;
	logic               fok_q;
	logic               found_q;
	logic [31:0]        vout_q;
	logic [IDX_W-1:0]   clr_q;
	logic               clr_reply_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   max_entries_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               req_fire;
	logic               commit_go;
	logic               cfg_wr;
	logic [IDX_W-1:0]   home;
	logic [IDX_W-1:0]   idx_inc;
	logic [IDX_W-1:0]   rd_addr;
	slot_state_t        rd_slot;
	logic [31:0]        rd_key;
	logic [31:0]        rd_value;
	logic               key_hit;
	logic               probe_end;
	logic               at_cap;
	logic               no_room;
	logic [IDX_W-1:0]   wr_addr;
	store_wr_t          wr;
	rsp_t               rsp_d;
	logic [CNT_W-1:0]   count_d;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_ENTRIES);
	assign prdata = (paddr[2] == REG_MAX_ENTRIES) ? 32'(max_entries_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= MAX_ENTRIES_RST;
		end else if (cfg_wr) begin
			max_entries_q <= pwdata[CNT_W-1:0];
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire = req.valid && req.ready;
	assign commit_go = (state_q == ST_COMMIT) && (!rsp_valid_q || rsp.ready);

	// home slot: low bits of key * multiplier depend only on low bits of both
	assign home = IDX_W'(key_q[IDX_W-1:0] * MULT_LO);
	assign idx_inc = idx_q + 1'b1;

	always_comb begin
		case (state_q)
			ST_HASH:  rd_addr = home;
			ST_PROBE: rd_addr = idx_inc;
			default:  rd_addr = idx_q;
		endcase
	end

	lpht_store #(
		.TABLE_SLOTS(TABLE_SLOTS),
		.IDX_W(IDX_W)
	) u_store (
		.clk(clk),
		.rd_addr(rd_addr),
		.rd_slot(rd_slot),
		.rd_key(rd_key),
		.rd_value(rd_value),
		.wr_addr(wr_addr),
		.wr(wr),
		.wr_key(key_q),
		.wr_value(value_q)
	);

	assign key_hit = (rd_slot == SLOT_USED) && (rd_key == key_q);
	assign probe_end = (rd_slot == SLOT_EMPTY) || key_hit || (n_q == LAST_PROBE);

	assign at_cap = (32'(count_q) >= 32'(TABLE_SLOTS)) || (count_q >= max_entries_q);
	assign no_room = at_cap || !fok_q;

	// commit: result and store update, or the slot clear during a sweep
	always_comb begin
		rsp_d = '0;
		count_d = count_q;
		wr = '0;
		wr.slot = SLOT_EMPTY;
		wr_addr = idx_q;
		rsp_d.found = found_q;
		rsp_d.status = STAT_DONE;
		if (state_q == ST_CLEAR) begin
			wr.slot_we = 1'b1;
			wr_addr = clr_q;
		end else begin
			case (op_q)
				OP_LOOKUP: begin
					if (found_q) begin
						rsp_d.value_out = vout_q;
					end else begin
						rsp_d.status = STAT_MISS;
					end
				end
				OP_INSERT: begin
					if (found_q) begin
						wr.value_we = commit_go;
					end else if (no_room) begin
						rsp_d.status = STAT_FULL;
					end else begin
						wr_addr = free_q;
						wr.slot_we = commit_go;
						wr.slot = SLOT_USED;
						wr.key_we = commit_go;
						wr.value_we = commit_go;
						count_d = count_q + 1'b1;
					end
				end
				OP_REMOVE: begin
					if (found_q) begin
						wr.slot_we = commit_go;
						wr.slot = SLOT_DELETED;
						if (count_q != '0) begin
							count_d = count_q - 1'b1;
						end
					end else begin
						rsp_d.status = STAT_MISS;
					end
				end
				default: begin
					rsp_d.found = 1'b0;
				end
			endcase
		end
		rsp_d.entry_count_out = count_d;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			clr_reply_q <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (commit_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (req.payload.op == OP_CLEAR) begin
							state_q     <= ST_CLEAR;
							clr_q       <= '0;
							clr_reply_q <= 1'b1;
							count_q     <= '0;
						end else begin
							state_q <= ST_HASH;
						end
					end
				end
				ST_HASH: begin
					state_q <= ST_PROBE;
				end
				ST_PROBE: begin
					if (probe_end) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (commit_go) begin
						count_q <= count_d;
						state_q <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) begin
						state_q <= clr_reply_q ? ST_COMMIT : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q    <= req.payload.op;
			key_q   <= req.payload.key;
			value_q <= req.payload.value;
			found_q <= 1'b0;
		end
		if (state_q == ST_HASH) begin
			idx_q <= home;
			n_q   <= '0;
			fok_q <= 1'b0;
		end
		if (state_q == ST_PROBE) begin
			// first deleted or empty slot on the path is the insert target
			if (!fok_q && (rd_slot != SLOT_USED)) begin
				free_q <= idx_q;
				fok_q  <= 1'b1;
			end
			if (probe_end) begin
				found_q <= key_hit;
				vout_q  <= rd_value;
			end else begin
				idx_q <= idx_inc;
				n_q   <= n_q + 1'b1;
			end
		end
		if (commit_go) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// checks
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(TABLE_SLOTS))
		else $error("entry count above slot count");

	a_commit_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		commit_go |=> rsp.valid)
		else $error("commit did not present a response");

	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> ($past(commit_go) || $past(req_fire)))
		else $error("entry count changed outside commit or clear");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> (32'(n_q) < 32'(TABLE_SLOTS)))
		else $error("probe ran past the table");

endmodule

### rtl/lpht_store.sv
// ----------------------------------------------------------------------------
// lpht_store
// Slot state, key and value memories: one registered read port, one write.
// ----------------------------------------------------------------------------
module lpht_store import lpht_pkg::*; #(
	parameter int TABLE_SLOTS = 256,
	parameter int IDX_W = $clog2(TABLE_SLOTS)
) (
	input  logic               clk,
	input  logic [IDX_W-1:0]   rd_addr,
	output slot_state_t        rd_slot,
	output logic [31:0]        rd_key,
	output logic [31:0]        rd_value,
	input  logic [IDX_W-1:0]   wr_addr,
	input  store_wr_t          wr,
	input  logic [31:0]        wr_key,
	input  logic [31:0]        wr_value
);

	slot_state_t slot_mem  [TABLE_SLOTS];
	logic [31:0] key_mem   [TABLE_SLOTS];
	logic [31:0] value_mem [TABLE_SLOTS];

	always_ff @(posedge clk) begin
		if (wr.slot_we) begin
			slot_mem[wr_addr] <= wr.slot;
		end
		rd_slot <= slot_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.key_we) begin
			key_mem[wr_addr] <= wr_key;
		end
		rd_key <= key_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.value_we) begin
			value_mem[wr_addr] <= wr_value;
		end
		rd_value <= value_mem[rd_addr];
	end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear probing hash table. Requests go in over
// the valid/ready request channel, and a software copy of the table predicts
// every response: found flag, value, status and entry count. Directed items
// cover field extremes, probe chains with deleted markers and the full and
// miss cases. Limit tests fill the table at both ends of the entry limit.
// Random phases run under several limits, most with random stalls on both
// channels. One test holds off the response side long enough that the
// request side backs up.
// ----------------------------------------------------------------------------
module tb;
	import lpht_pkg::*;

	localparam int SLOTS       = 256;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 8000;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lpht_req_if req_ch ();
	lpht_rsp_if rsp_ch ();

	linear_probe_hash_table #(.TABLE_SLOTS(SLOTS)) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// software copy of the table
	slot_state_t      tbl_state [SLOTS];
	logic [31:0]      tbl_key   [SLOTS];
	logic [31:0]      tbl_val   [SLOTS];
	logic [CNT_W-1:0] live_count;
	logic [CNT_W-1:0] max_entries;

	rsp_t        pending_rsp [$];
	logic [31:0] key_pool [$];

	bit no_idle;
	int hold_reqs;
	int n_err, n_req, n_rsp, n_hit, n_miss, n_full, n_clear, n_cfg;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("ERROR %0t: %s", $time, msg);
		n_err++;
	endtask

	// Applies one request to the software table and returns its response.
	function automatic rsp_t table_apply(input req_t r);
		rsp_t        o;
		logic [31:0] k;
		logic [31:0] h;
		logic [7:0]  idx;
		logic [7:0]  hit_idx;
		logic [7:0]  free_idx;
		bit          free_ok;
		bit          hit;
		int          lim;
		o = '{found: 1'b0, value_out: '0, status: STAT_DONE, entry_count_out: '0};
		k = r.key;
		hit = 1'b0;
		free_ok = 1'b0;
		free_idx = '0;
		hit_idx = '0;
		lim = (max_entries > SLOTS) ? SLOTS : max_entries;
		if (r.op == OP_CLEAR) begin
			foreach (tbl_state[i]) tbl_state[i] = SLOT_EMPTY;
			live_count = '0;
			n_clear++;
		end else begin
			h = k * HASH_MULT;
			idx = h[7:0];
			for (int n = 0; n < SLOTS; n++) begin
				if (tbl_state[idx] == SLOT_EMPTY) begin
					if (!free_ok) begin
						free_idx = idx;
						free_ok = 1'b1;
					end
					break;
				end
				if (tbl_state[idx] == SLOT_DELETED) begin
					if (!free_ok) begin
						free_idx = idx;
						free_ok = 1'b1;
					end
				end else if (tbl_key[idx] == k) begin
					hit = 1'b1;
					hit_idx = idx;
					break;
				end
				idx++;
			end
			if (hit) begin
				o.found = 1'b1;
				n_hit++;
				case (r.op)
					OP_LOOKUP: o.value_out = tbl_val[hit_idx];
					OP_INSERT: tbl_val[hit_idx] = r.value;
					default: begin
						tbl_state[hit_idx] = SLOT_DELETED;
						if (live_count > 0) live_count--;
					end
				endcase
			end else if (r.op == OP_INSERT) begin
				if (live_count >= lim || !free_ok) begin
					o.status = STAT_FULL;
					n_full++;
				end else begin
					tbl_key[free_idx] = k;
					tbl_val[free_idx] = r.value;
					tbl_state[free_idx] = SLOT_USED;
					live_count++;
				end
			end else begin
				o.status = STAT_MISS;
				n_miss++;
			end
		end
		o.entry_count_out = live_count;
		return o;
	endfunction

	task automatic send_req(input op_t op, input logic [31:0] key, input logic [31:0] value);
		@(negedge clk);
		if (!no_idle) begin
			while ($urandom_range(0, 99) < 11) begin
				req_ch.valid = 1'b0;
				@(negedge clk);
			end
		end
		req_ch.valid = 1'b1;
		req_ch.payload = '{op: op, key: key, value: value};
		do @(posedge clk); while (!req_ch.ready);
		n_req++;
		pending_rsp.push_back(table_apply(req_ch.payload));
	endtask

	// stop offering and wait for every outstanding response
	task automatic drain();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic check_max_entries();
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = {REG_MAX_ENTRIES, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {23'b0, max_entries})
			report_mismatch($sformatf("max_entries read %0d, expected %0d", prdata, max_entries));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic set_max_entries(input logic [CNT_W-1:0] lim);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {REG_MAX_ENTRIES, 2'b00};
		pwdata = {23'b0, lim};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		max_entries = lim;
		n_cfg++;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		check_max_entries();
	endtask

	// Keys sharing the low byte share a home slot, so half the pool clusters.
	task automatic build_pool(input int n);
		logic [31:0] k;
		key_pool.delete();
		repeat (n) begin
			k = $urandom;
			if ($urandom_range(0, 1)) k[7:0] = 8'($urandom_range(0, 15));
			key_pool.push_back(k);
		end
	endtask

	function automatic logic [31:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 2) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		if (r < 12) return $urandom;
		return key_pool[$urandom_range(0, key_pool.size() - 1)];
	endfunction

	function automatic op_t pick_op();
		int r;
		r = $urandom_range(0, 199);
		if (r < 1) return OP_CLEAR;
		if (r < 80) return OP_INSERT;
		if (r < 140) return OP_LOOKUP;
		return OP_REMOVE;
	endfunction

	task automatic test_directed();
		logic [31:0] ka, kb, kc, kd;
		ka = 32'h0000_0011;
		kb = 32'h0100_0011;
		kc = 32'h7F00_0011;
		kd = 32'hFF00_0011;
		send_req(OP_LOOKUP, 32'h0, 32'hFFFF_FFFF);      // miss on empty table
		send_req(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_req(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_req(OP_INSERT, 32'h0, 32'h0);
		send_req(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_req(OP_LOOKUP, 32'h8000_0000, 32'h0);
		send_req(OP_LOOKUP, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		// one probe chain on a single home slot
		send_req(OP_INSERT, ka, 32'd1);
		send_req(OP_INSERT, kb, 32'd2);
		send_req(OP_INSERT, kc, 32'd3);
		send_req(OP_REMOVE, kb, 32'h0);
		send_req(OP_LOOKUP, kc, 32'h0);                 // walks past the deleted marker
		send_req(OP_LOOKUP, kb, 32'h0);
		send_req(OP_INSERT, kd, 32'd4);                 // lands in the deleted slot
		send_req(OP_INSERT, ka, 32'd5);                 // update keeps the count
		send_req(OP_REMOVE, kb, 32'h0);
		send_req(OP_LOOKUP, ka, 32'h0);
		send_req(OP_REMOVE, 32'h8000_0000, 32'h0);
		send_req(OP_CLEAR, 32'h1234_5678, 32'h9ABC_DEF0);
		send_req(OP_LOOKUP, kc, 32'h0);
		send_req(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
		send_req(OP_INSERT, kc, 32'h1234_5678);
		send_req(OP_LOOKUP, kc, 32'h0);
		drain();
	endtask

	task automatic test_limit_edges();
		logic [31:0] k1, k2;
		logic [31:0] fill_keys [$];
		k1 = $urandom;
		k2 = k1 ^ 32'h0100_0000;
		set_max_entries(9'd1);
		send_req(OP_CLEAR, $urandom, $urandom);
		send_req(OP_INSERT, k1, $urandom);
		send_req(OP_INSERT, k2, $urandom);              // refused at the limit
		send_req(OP_INSERT, k1, $urandom);              // update still allowed
		send_req(OP_LOOKUP, k2, $urandom);
		send_req(OP_REMOVE, k1, $urandom);
		send_req(OP_INSERT, k2, $urandom);
		send_req(OP_LOOKUP, k2, $urandom);
		drain();

		set_max_entries(9'd256);
		send_req(OP_CLEAR, $urandom, $urandom);
		// distinct top bytes keep the keys unique, random low bytes collide
		for (int i = 0; i < SLOTS; i++) begin
			fill_keys.push_back({8'(i), 24'($urandom)});
			send_req(OP_INSERT, fill_keys[i], $urandom);
		end
		send_req(OP_INSERT, $urandom, $urandom);
		send_req(OP_LOOKUP, $urandom, $urandom);        // walks the whole table
		repeat (10) send_req(OP_LOOKUP, fill_keys[$urandom_range(0, SLOTS - 1)], $urandom);
		for (int i = 0; i < 16; i++) send_req(OP_REMOVE, fill_keys[i * 16], $urandom);
		for (int i = 0; i < 16; i++) send_req(OP_LOOKUP, fill_keys[i * 16], $urandom);
		repeat (16) send_req(OP_INSERT, $urandom, $urandom);
		send_req(OP_INSERT, $urandom, $urandom);
		send_req(OP_CLEAR, $urandom, $urandom);
		drain();
	endtask

	task automatic test_random_phase(input logic [CNT_W-1:0] lim, input int n, input bit quiet);
		drain();
		set_max_entries(lim);
		build_pool(lim + lim / 4 + 4);
		no_idle = quiet;
		repeat (n) send_req(pick_op(), pick_key(), $urandom);
		drain();
		no_idle = 1'b0;
	endtask

	// response side stops for a long stretch while requests keep coming
	task automatic test_backpressure();
		build_pool(24);
		hold_reqs++;
		repeat (24) send_req(pick_op(), pick_key(), $urandom);
		drain();
	endtask

	initial begin : rsp_sink
		int hold_done;
		hold_done = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_done != hold_reqs) begin
				hold_done++;
				rsp_ch.ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				rsp_ch.ready = no_idle || ($urandom_range(0, 99) >= 11);
			end
		end
	end

	always @(posedge clk) begin : rsp_check
		rsp_t got;
		rsp_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.payload;
			n_rsp++;
			if (pending_rsp.size() == 0) begin
				report_mismatch($sformatf("response with none pending: %p", got));
			end else begin
				want = pending_rsp.pop_front();
				if (got.found !== want.found)
					report_mismatch($sformatf("found %b, expected %b", got.found, want.found));
				if (got.value_out !== want.value_out)
					report_mismatch($sformatf("value_out %h, expected %h",
						got.value_out, want.value_out));
				if (got.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						got.status, want.status));
				if (got.entry_count_out !== want.entry_count_out)
					report_mismatch($sformatf("entry count %0d, expected %0d",
						got.entry_count_out, want.entry_count_out));
			end
		end
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("FAIL linear_probe_hash_table");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		no_idle = 1'b0;
		hold_reqs = 0;
		foreach (tbl_state[i]) tbl_state[i] = SLOT_EMPTY;
		live_count = '0;
		max_entries = MAX_ENTRIES_RST;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		check_max_entries();
		test_directed();
		test_limit_edges();
		test_random_phase(9'd255, 200, 1'b0);
		test_random_phase(9'($urandom_range(2, 64)), 200, 1'b1);
		test_random_phase(9'd256, 200, 1'b0);
		test_random_phase(9'd192, 200, 1'b0);
		test_random_phase(9'($urandom_range(65, 254)), 200, 1'b0);
		test_random_phase(9'd8, 200, 1'b0);
		test_backpressure();

		drain();
		repeat (300) @(posedge clk);
		$display("Run covered %0d requests and %0d responses: %0d hits, %0d misses,",
			n_req, n_rsp, n_hit, n_miss);
		$display("%0d full refusals, %0d clears, %0d limit writes, one %0d-cycle output hold.",
			n_full, n_clear, n_cfg, HOLD_CYCLES);
		if (n_err == 0) begin
			$display("PASS linear_probe_hash_table");
		end else begin
			$display("FAIL linear_probe_hash_table");
		end
		$finish;
	end

endmodule
